// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every rising clock edge outside reset.
`define MIC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be true outside reset.
`define MIC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`MIC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: src/mic_pkg.sv
`default_nettype none

package mic_pkg;

	localparam int WORD_W             = 64;
	localparam int SLOT_W             = 12;
	localparam int IDXB_W             = 4;
	localparam int EPOCH_W            = 8;
	localparam int MAX_INDEX_BITS_DEF = 12;
	localparam int CFG_IDX_W          = 2;

	localparam int IN_USED_W   = 2 * WORD_W + SLOT_W;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_USED_W  = SLOT_W + 2 + WORD_W + 1;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = CFG_IDX_W'(1);

	localparam logic [IDXB_W-1:0] INDEX_BITS_RST = IDXB_W'(12);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_LOOK,
		ST_RESOLVE
	} st_t;

	typedef struct packed {
		logic              cmd;
		logic [WORD_W-1:0] occupancy;
		logic [WORD_W-1:0] attack;
		logic              last;
		logic [SLOT_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic              collision;
		logic              run_done;
		logic              run_ok;
		logic [WORD_W-1:0] read_data;
		logic              read_valid;
	} res_t;

endpackage

`default_nettype wire

// File: src/mic_ram.sv
`default_nettype none

module mic_ram #(
	parameter int Width = 72,
	parameter int Depth = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/mic_hash.sv
`default_nettype none

module mic_hash import mic_pkg::*; #(
	parameter int MaxIndexBits = MAX_INDEX_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic [WORD_W-1:0]       occupancy,
	input  wire logic [WORD_W-1:0]       magic,
	input  wire logic [IDXB_W-1:0]       index_bits,
	output logic      [MaxIndexBits-1:0] index
);

	localparam int KCLOG = $clog2(MaxIndexBits + 1);
	localparam int KW    = (KCLOG > IDXB_W) ? KCLOG : IDXB_W;
	localparam int HW    = WORD_W / 2;

	logic [KW-1:0]           k_raw;
	logic [KW-1:0]           k_eff;
	logic [KW-1:0]           sh_d;
	logic [WORD_W-1:0]       ll_d;
	logic [HW-1:0]           lh_d;
	logic [HW-1:0]           hl_d;

	logic                    vld_s1;
	logic [WORD_W-1:0]       ll_s1;
	logic [HW-1:0]           lh_s1;
	logic [HW-1:0]           hl_s1;
	logic [KW-1:0]           sh_s1;

	logic [HW-1:0]           hi_sum;
	logic [WORD_W-1:0]       prod;
	logic [MaxIndexBits-1:0] top_bits;
	logic [MaxIndexBits-1:0] index_s2;

	always_comb begin
		k_raw = KW'(index_bits);
		k_eff = k_raw;
		if (k_raw == '0) begin
			k_eff = KW'(1);
		end else if (k_raw > KW'(MaxIndexBits)) begin
			k_eff = KW'(MaxIndexBits);
		end
		sh_d = KW'(MaxIndexBits) - k_eff;
	end

	assign ll_d = {HW'(0), occupancy[HW-1:0]} * {HW'(0), magic[HW-1:0]};
	assign lh_d = occupancy[HW-1:0] * magic[WORD_W-1:HW];
	assign hl_d = occupancy[WORD_W-1:HW] * magic[HW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= en;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll_d;
			lh_s1 <= lh_d;
			hl_s1 <= hl_d;
			sh_s1 <= sh_d;
		end
		if (vld_s1) begin
			index_s2 <= top_bits >> sh_s1;
		end
	end

	assign hi_sum   = ll_s1[WORD_W-1:HW] + lh_s1 + hl_s1;
	assign prod     = {hi_sum, ll_s1[HW-1:0]};
	assign top_bits = prod[WORD_W-1 -: MaxIndexBits];
	assign index    = index_s2;

endmodule

`default_nettype wire

// File: src/mic_seq.sv
`default_nettype none
`include "assert_macros.svh"

module mic_seq import mic_pkg::*; #(
	parameter int MaxIndexBits = MAX_INDEX_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire item_t                   item,
	input  wire logic [MaxIndexBits-1:0] hash_index,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output res_t                         res
);

	localparam int AW    = MaxIndexBits;
	localparam int Depth = 1 << MaxIndexBits;
	localparam int RW    = WORD_W + EPOCH_W;
	localparam int WideW = (AW > SLOT_W) ? AW : SLOT_W;

	st_t               state_q;
	st_t               state_d;
	logic              cmd_q;
	logic              last_q;
	logic [WORD_W-1:0] atk_q;
	logic [AW-1:0]     raddr_q;
	logic [AW-1:0]     slot_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]     clr_addr_q;
	logic              collided_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              in_fire;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [RW-1:0]     ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [RW-1:0]     ram_rdata;
	logic              resolve_fire;
	logic              hit;
	logic              coll_new;
	logic              run_end;
	logic              epoch_wrap;
	logic [WideW-1:0]  ridx_wide;
	logic [WideW-1:0]  slot_wide;
	res_t              res_d;

	assign in_fire   = in_valid && in_ready;
	assign ridx_wide = WideW'(item.read_index);
	assign slot_wide = WideW'(slot_q);

	assign hit        = (ram_rdata[RW-1 -: EPOCH_W] == epoch_q);
	assign coll_new   = collided_q || hit;
	assign run_end    = (cmd_q == CMD_INSERT) && last_q;
	assign epoch_wrap = (epoch_q == '1);

	always_comb begin
		res_d            = '0;
		res_d.slot_index = slot_wide[SLOT_W-1:0];
		if (cmd_q == CMD_READ) begin
			res_d.collision  = collided_q;
			res_d.read_valid = hit;
			res_d.read_data  = hit ? ram_rdata[WORD_W-1:0] : '0;
		end else begin
			res_d.collision = coll_new;
			res_d.run_done  = last_q;
			res_d.run_ok    = last_q && !coll_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = slot_q;
		ram_wdata    = {epoch_q, atk_q};
		ram_re       = 1'b0;
		ram_raddr    = (cmd_q == CMD_READ) ? raddr_q : hash_index;
		resolve_fire = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				ram_re  = 1'b1;
				state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				if (!out_valid_q || out_ready) begin
					resolve_fire = 1'b1;
					ram_we       = (cmd_q == CMD_INSERT) && !collided_q && !hit;
					state_d      = (run_end && epoch_wrap) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= EPOCH_W'(1);
			clr_addr_q  <= '0;
			collided_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (resolve_fire) begin
				if (run_end) begin
					collided_q <= 1'b0;
					epoch_q    <= epoch_wrap ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
				end else if (cmd_q == CMD_INSERT) begin
					collided_q <= coll_new;
				end
			end
			if (resolve_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= item.cmd;
			last_q  <= item.last;
			atk_q   <= item.attack;
			raddr_q <= ridx_wide[AW-1:0];
		end
		if (ram_re) begin
			slot_q <= ram_raddr;
		end
		if (resolve_fire) begin
			res_q <= res_d;
		end
	end

	mic_ram #(
		.Width(RW),
		.Depth(Depth)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign res       = res_q;

	`MIC_ASSERT(a_run_end_clears, clk, arst_n, (resolve_fire && run_end) |=> !collided_q, "collided flag survived end of run")
	`MIC_ASSERT(a_store_only_empty, clk, arst_n, (ram_we && state_q == ST_RESOLVE) |-> (!hit && !collided_q && cmd_q == CMD_INSERT), "table write into occupied slot or after collision")
	`MIC_ASSERT(a_look_to_resolve, clk, arst_n, (state_q == ST_LOOK) |=> (state_q == ST_RESOLVE && ram_raddr == slot_q), "table read not followed by resolve")
	`MIC_ASSERT_NEVER(a_epoch_nonzero, clk, arst_n, epoch_q == '0, "epoch reached the empty tag")

endmodule

`default_nettype wire

// File: src/magic_index_collision_checker_top.sv
`default_nettype none

// Channel  Dir  Signals                          Payload
// s_axis   in   tvalid tready tdata tlast tuser  insert pair or table read
// m_axis   out  tvalid tready tdata tlast        one result per item
// cfg      in   cfg_valid cfg_ready cfg_index    register write, always ready
//
// An item is accepted while its 32-bit partial products are registered; then the
// top bits are extracted, the table is read, and the item is resolved and written
// back. The next item is accepted only after resolve, so items do not overlap.
// The result waits in the output register while the next item is accepted;
// a stalled m_axis holds resolve only.
// After reset the table is swept, all 2**MaxIndexBits entries, before the first
// transfer; the sweep recurs after every 255th completed run (epoch wrap).

module magic_index_collision_checker_top import mic_pkg::*; #(
	parameter int MaxIndexBits = MAX_INDEX_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// occupancy[63:0], attack[127:64], read_index[139:128], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic                   s_axis_tlast,
	// cmd
	input  wire logic                   s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// slot_index[11:0], collision[12], run_ok[13], read_data[77:14],
	// read_valid[78], zero pad
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [WORD_W-1:0]      cfg_data
);

	logic [WORD_W-1:0]       magic_q;
	logic [IDXB_W-1:0]       index_bits_q;
	logic                    in_fire;
	item_t                   item;
	logic [MaxIndexBits-1:0] hash_index;
	res_t                    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q      <= '0;
			index_bits_q <= INDEX_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAGIC:      magic_q      <= cfg_data;
				REG_INDEX_BITS: index_bits_q <= cfg_data[IDXB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_comb begin
		item.cmd        = s_axis_tuser;
		item.occupancy  = s_axis_tdata[WORD_W-1:0];
		item.attack     = s_axis_tdata[2*WORD_W-1:WORD_W];
		item.last       = s_axis_tlast;
		item.read_index = s_axis_tdata[2*WORD_W +: SLOT_W];
	end

	mic_hash #(
		.MaxIndexBits(MaxIndexBits)
	) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (in_fire),
		.occupancy (item.occupancy),
		.magic     (magic_q),
		.index_bits(index_bits_q),
		.index     (hash_index)
	);

	mic_seq #(
		.MaxIndexBits(MaxIndexBits)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.item      (item),
		.hash_index(hash_index),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {
		(OUT_TDATA_W - OUT_USED_W)'(0),
		res.read_valid,
		res.read_data,
		res.run_ok,
		res.collision,
		res.slot_index
	};
	assign m_axis_tlast = res.run_done;

endmodule

`default_nettype wire
